@@ hdl/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsc_pkg - shared types and helpers for the Hamming SEC codec
// Field widths, command/status codes, config register indexes and the fixed
// position tables of the code.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int WORD_W        = 63;
  localparam int POS_W         = 6;
  localparam int STAT_W        = 2;
  localparam int CHK_MAX       = 6;
  localparam int CFG_DATA_W    = 6;
  localparam int IN_TDATA_W    = 64;
  localparam int OUT_TDATA_W   = 72;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FIXED  = 2'd1,
    STAT_UNCORR = 2'd2
  } status_e;

  typedef enum logic {
    CFG_DATA_BITS  = 1'b0,
    CFG_ODD_PARITY = 1'b1
  } cfg_idx_e;

  // derived code geometry, kept in registers by the config block
  typedef struct packed {
    logic              odd;
    logic [POS_W-1:0]  len;
    logic [CHK_MAX-1:0] chk_mask;
    logic [WORD_W-1:0] len_mask;
  } hsc_cfg_t;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  err_pos;
    logic [WORD_W-1:0] word;
  } hsc_res_t;

  // message bit k goes to the k-th non power-of-two position
  function automatic logic [WORD_W-1:0] scatter(logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] w;
    int                k;
    w = '0;
    k = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = d[k];
        k++;
      end
    end
    return w;
  endfunction

  // positions covered by check bit i
  function automatic logic [WORD_W-1:0] grp_mask(int i);
    logic [WORD_W-1:0] g;
    g = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      g[p-1] = ((p >> i) & 1) != 0;
    end
    return g;
  endfunction

  function automatic hsc_cfg_t derive(logic [CFG_DATA_W-1:0] bits, logic odd);
    hsc_cfg_t           c;
    logic [POS_W-1:0]   m;
    logic [2:0]         r;
    if (bits == '0) begin
      m = POS_W'(1);
    end else if (bits > POS_W'(MAX_DATA_BITS)) begin
      m = POS_W'(MAX_DATA_BITS);
    end else begin
      m = bits;
    end
    if (m <= POS_W'(1)) begin
      r = 3'd2;
    end else if (m <= POS_W'(4)) begin
      r = 3'd3;
    end else if (m <= POS_W'(11)) begin
      r = 3'd4;
    end else if (m <= POS_W'(26)) begin
      r = 3'd5;
    end else begin
      r = 3'd6;
    end
    c.odd      = odd;
    c.len      = m + POS_W'(r);
    c.chk_mask = CHK_MAX'((7'd1 << r) - 7'd1);
    c.len_mask = WORD_W'((64'd1 << c.len) - 64'd1);
    return c;
  endfunction

endpackage

@@ hdl/hsc_cfg.sv @@
// ----------------------------------------------------------------------------
// hsc_cfg - configuration registers
// Takes register writes and keeps the code geometry derived from them.
// ----------------------------------------------------------------------------
module hsc_cfg import hsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_idx_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output hsc_cfg_t              cfg_o
);

  logic [CFG_DATA_W-1:0] bits_q, bits_d;
  logic                  odd_q, odd_d;
  hsc_cfg_t              geo_q, geo_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    bits_d = bits_q;
    odd_d  = odd_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DATA_BITS:  bits_d = cfg_data_i;
        CFG_ODD_PARITY: odd_d  = cfg_data_i[0];
        default: ;
      endcase
    end
    geo_d = derive(bits_d, odd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= CFG_DATA_W'(4);
      odd_q  <= 1'b0;
      geo_q  <= derive(CFG_DATA_W'(4), 1'b0);
    end else begin
      bits_q <= bits_d;
      odd_q  <= odd_d;
      geo_q  <= geo_d;
    end
  end

  assign cfg_o = geo_q;

endmodule

@@ hdl/hsc_core.sv @@
// ----------------------------------------------------------------------------
// hsc_core - encode / decode datapath
// Shared parity trees; encode inserts check bits, decode corrects one bit.
// ----------------------------------------------------------------------------
module hsc_core import hsc_pkg::*; (
  input  cmd_e              cmd_i,
  input  logic [WORD_W-1:0] payload_i,
  input  hsc_cfg_t          cfg_i,
  output hsc_res_t          res_o
);

  logic [WORD_W-1:0]  base;
  logic [CHK_MAX-1:0] par;
  logic [POS_W-1:0]   syn;
  logic [WORD_W-1:0]  code;

  always_comb begin
    if (cmd_i == CMD_ENCODE) begin
      base = scatter(payload_i) & cfg_i.len_mask;
    end else begin
      base = payload_i & cfg_i.len_mask;
    end
    for (int i = 0; i < CHK_MAX; i++) begin
      par[i] = ^(base & grp_mask(i)) ^ cfg_i.odd;
    end
    syn = par & cfg_i.chk_mask;

    code          = base;
    res_o.err_pos = '0;
    res_o.status  = STAT_OK;
    if (cmd_i == CMD_ENCODE) begin
      for (int i = 0; i < CHK_MAX; i++) begin
        if (cfg_i.chk_mask[i]) begin
          code[(1 << i) - 1] = par[i];
        end
      end
    end else begin
      res_o.err_pos = syn;
      if (syn == '0) begin
        res_o.status = STAT_OK;
      end else if (syn <= cfg_i.len) begin
        code         = base ^ (WORD_W'(1) << (syn - POS_W'(1)));
        res_o.status = STAT_FIXED;
      end else begin
        res_o.status = STAT_UNCORR;
      end
    end
    res_o.word = code & cfg_i.len_mask;
  end

endmodule

@@ hdl/hamming_sec_codec.sv @@
// ----------------------------------------------------------------------------
// hamming_sec_codec - single-error-correcting Hamming encoder / decoder
// Input stream: tuser = command (0 encode, 1 decode), tdata = payload.
// Output stream: tdata = result word, error position, status.
// Config channel: index 0 data_bits (1..57, clamped), index 1 odd_parity.
// Write config only while no transaction is in flight.
//
// One transaction per cycle sustained while the receiver takes every result. From input
// accept to output valid a transaction passes an input register, then the
// parity trees and the correction decoder, then the output register.
// When the receiver stalls the output register holds its result and the
// input register still takes one more transaction; tready drops only when
// both are full.
// Reset empties both registers and sets 4 data bits, even parity.
// ----------------------------------------------------------------------------
module hamming_sec_codec import hsc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [62:0] payload, [63] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [62:0] result_word, [68:63] error_position, [70:69] status, [71] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  hsc_cfg_t          cfg;
  hsc_res_t          res;
  logic              in_valid_q, in_valid_d;
  cmd_e              in_cmd_q;
  logic [WORD_W-1:0] in_data_q;
  logic              out_valid_q, out_valid_d;
  hsc_res_t          out_res_q;
  logic              out_adv;

  hsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hsc_core u_core (
    .cmd_i     (in_cmd_q),
    .payload_i (in_data_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_adv;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    if (out_adv) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata[WORD_W-1:0];
    end
    if (in_valid_q && out_adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q};

`ifndef SYNTH
  a_fixed_has_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status == STAT_FIXED |-> out_res_q.err_pos != '0)
    else $error("corrected result without error position");

  a_ok_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status == STAT_OK |-> out_res_q.err_pos == '0)
    else $error("clean result with nonzero error position");

  a_word_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.word & ~cfg.len_mask) == '0)
    else $error("result word has bits beyond codeword length");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
